FILE: rtl/oaht_pkg.sv
// Shared constants and types for the open-address hash table unit.
`default_nettype none

package oaht_pkg;

	localparam int SLOTS      = 16;
	localparam int IDX_W      = $clog2(SLOTS);
	localparam int KEY_W      = 32;
	localparam int VAL_W      = 32;
	localparam int CNT_W      = 5;
	localparam int PROBE_STEP = 2;

	typedef enum logic [1:0] {
		CMD_GET     = 2'd0,
		CMD_SET     = 2'd1,
		CMD_DISCARD = 2'd2,
		CMD_CLEAR   = 2'd3
	} oaht_cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} oaht_status_t;

	typedef enum logic [1:0] {
		MARK_EMPTY   = 2'd0,
		MARK_REMOVED = 2'd1,
		MARK_ACTIVE  = 2'd2
	} oaht_mark_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_FINISH
	} oaht_state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic probe;
		logic finish;
	} oaht_ctl_t;

	// Datapath to controller status.
	typedef struct packed {
		logic probe_stop;
	} oaht_sts_t;

endpackage

`default_nettype wire

FILE: rtl/open_address_hash_table_unit.sv
// Top level of the open-address hash table unit.
//
// Sixteen-slot key/value table with quadratic probing (steps 0, 2, 4, ...).
// Pulse start while busy is low to transfer a command (get, set, discard, clear).
// Busy stays high while the command works; one result follows per command on
// status, read_value and entries_used for exactly one cycle, marked by done,
// and the receiver must take it then. Done is registered from the finish state,
// which follows the probe state; the probe loop reads one slot per cycle and
// probes 1 to 16 slots per command. A clear probes once.
// A new command may be transferred in the cycle done is high.
`default_nettype none

module open_address_hash_table_unit import oaht_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [1:0]       command,
	input  wire logic [KEY_W-1:0] key,
	input  wire logic [VAL_W-1:0] write_value,
	output logic                  done,
	output logic [1:0]            status,
	output logic [VAL_W-1:0]      read_value,
	output logic [CNT_W-1:0]      entries_used
);

	oaht_ctl_t ctl;
	oaht_sts_t sts;

	oaht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	oaht_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.command      (command),
		.key          (key),
		.write_value  (write_value),
		.sts          (sts),
		.status       (status),
		.read_value   (read_value),
		.entries_used (entries_used)
	);

	// A result is shown only once the unit is free again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// Count never exceeds the slot count.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		entries_used <= CNT_W'(SLOTS))
		else $error("entries_used out of range");

	// Read value is zero for every result whose status is not OK.
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (read_value == '0))
		else $error("read_value nonzero on failure");

	// An accepted command makes the unit busy next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy missing after transfer");

endmodule

`default_nettype wire

FILE: rtl/oaht_ctrl.sv
// Sequencing state machine for the open-address hash table unit.
`default_nettype none

module oaht_ctrl import oaht_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire oaht_sts_t sts,
	output oaht_ctl_t      ctl,
	output logic           busy,
	output logic           done
);

	oaht_state_t state_q, state_d;
	logic        done_q;

	// Advance the state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FINISH);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (start) state_d = S_PROBE;
			S_PROBE:  if (sts.probe_stop) state_d = S_FINISH;
			S_FINISH: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_IDLE:   ctl.load   = start;
			S_PROBE:  ctl.probe  = 1'b1;
			S_FINISH: ctl.finish = 1'b1;
			default:  ctl = '0;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

`default_nettype wire

FILE: rtl/oaht_dp.sv
// Slot stores, probe sequencing registers and result registers.
`default_nettype none

module oaht_dp import oaht_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire oaht_ctl_t        ctl,
	input  wire logic [1:0]       command,
	input  wire logic [KEY_W-1:0] key,
	input  wire logic [VAL_W-1:0] write_value,
	output oaht_sts_t             sts,
	output logic [1:0]            status,
	output logic [VAL_W-1:0]      read_value,
	output logic [CNT_W-1:0]      entries_used
);

	// Slot stores; marks reset to empty, key and value are valid only when active.
	logic [KEY_W-1:0] slot_key_q   [SLOTS];
	logic [VAL_W-1:0] slot_value_q [SLOTS];
	oaht_mark_t       slot_mark_q  [SLOTS];
	logic [CNT_W-1:0] count_q;

	// Command under work.
	oaht_cmd_t        cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;

	// Probe state.
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] step_q;
	logic [IDX_W-1:0] n_q;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic             free_vld_q;
	logic [IDX_W-1:0] free_idx_q;

	// Result registers.
	oaht_status_t     status_q;
	logic [VAL_W-1:0] rd_q;

	oaht_mark_t       mark_cur;
	logic             key_match;
	logic             last_probe;

	// Examine the slot at the current probe index.
	always_comb begin
		mark_cur   = slot_mark_q[idx_q];
		key_match  = (mark_cur == MARK_ACTIVE) && (slot_key_q[idx_q] == key_q);
		last_probe = (n_q == IDX_W'(SLOTS - 1));
		sts.probe_stop = (cmd_q == CMD_CLEAR) || key_match || (mark_cur == MARK_EMPTY)
			|| last_probe;
	end

	// Latch the command and walk the probe sequence.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q      <= oaht_cmd_t'(command);
			key_q      <= key;
			val_q      <= write_value;
			idx_q      <= key[IDX_W-1:0];
			step_q     <= '0;
			n_q        <= '0;
			hit_q      <= 1'b0;
			free_vld_q <= 1'b0;
		end else if (ctl.probe) begin
			if (key_match) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_q;
			end
			if ((mark_cur != MARK_ACTIVE) && !free_vld_q) begin
				free_vld_q <= 1'b1;
				free_idx_q <= idx_q;
			end
			idx_q  <= idx_q + step_q;
			step_q <= step_q + IDX_W'(PROBE_STEP);
			n_q    <= n_q + IDX_W'(1);
		end
	end

	// Apply the command to key and value stores and form the result payload.
	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			case (cmd_q)
				CMD_GET: begin
					if (hit_q) begin
						status_q <= ST_OK;
						rd_q     <= slot_value_q[hit_idx_q];
					end else begin
						status_q <= ST_NOT_FOUND;
						rd_q     <= '0;
					end
				end
				CMD_SET: begin
					rd_q <= '0;
					if (hit_q) begin
						status_q                <= ST_OK;
						slot_value_q[hit_idx_q] <= val_q;
					end else if (free_vld_q) begin
						status_q                 <= ST_OK;
						slot_key_q[free_idx_q]   <= key_q;
						slot_value_q[free_idx_q] <= val_q;
					end else begin
						status_q <= ST_FULL;
					end
				end
				CMD_DISCARD: begin
					rd_q     <= '0;
					status_q <= hit_q ? ST_OK : ST_NOT_FOUND;
				end
				default: begin
					rd_q     <= '0;
					status_q <= ST_OK;
				end
			endcase
		end
	end

	// Update slot marks and the active count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) slot_mark_q[i] <= MARK_EMPTY;
			count_q <= '0;
		end else if (ctl.finish) begin
			case (cmd_q)
				CMD_SET: begin
					if (!hit_q && free_vld_q) begin
						slot_mark_q[free_idx_q] <= MARK_ACTIVE;
						count_q <= count_q + CNT_W'(1);
					end
				end
				CMD_DISCARD: begin
					if (hit_q) begin
						slot_mark_q[hit_idx_q] <= MARK_REMOVED;
						if (count_q != '0) count_q <= count_q - CNT_W'(1);
					end
				end
				CMD_CLEAR: begin
					for (int i = 0; i < SLOTS; i++) slot_mark_q[i] <= MARK_EMPTY;
					count_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign status       = status_q;
	assign read_value   = rd_q;
	assign entries_used = count_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for the open-address hash table unit: directed and random commands against a behavioral table.

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import oaht_pkg::*;

	typedef struct {
		oaht_status_t     status;
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] used;
	} table_result_t;

	logic             clk;
	logic             arst_n      = 1'b0;
	logic             start       = 1'b0;
	logic [1:0]       command     = CMD_GET;
	logic [KEY_W-1:0] key         = '0;
	logic [VAL_W-1:0] write_value = '0;
	logic             busy;
	logic             done;
	logic [1:0]       status;
	logic [VAL_W-1:0] read_value;
	logic [CNT_W-1:0] entries_used;

	// behavioral copy of the table
	logic [KEY_W-1:0] shadow_key [SLOTS];
	logic [VAL_W-1:0] shadow_val [SLOTS];
	oaht_mark_t       shadow_mark [SLOTS];
	int unsigned      shadow_count;

	table_result_t    pending_results [$];
	int unsigned      commands_sent = 0;
	int unsigned      results_seen  = 0;
	int unsigned      full_seen     = 0;
	int unsigned      mismatches    = 0;
	logic [CNT_W-1:0] peak_used     = '0;
	bit               no_gaps       = 1'b0;

	open_address_hash_table_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.key          (key),
		.write_value  (write_value),
		.done         (done),
		.status       (status),
		.read_value   (read_value),
		.entries_used (entries_used)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		foreach (shadow_mark[i]) shadow_mark[i] = MARK_EMPTY;
		shadow_count = 0;
	end

	// Run one command against the shadow table and return what the unit must report.
	function automatic table_result_t table_lookup_update(oaht_cmd_t cmd, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		table_result_t r;
		int unsigned   idx;
		int unsigned   step;
		int unsigned   hit;
		int unsigned   free_slot;
		bit            searching;
		r.status  = ST_OK;
		r.value   = '0;
		hit       = SLOTS;
		free_slot = SLOTS;
		if (cmd == CMD_CLEAR) begin
			foreach (shadow_mark[i]) shadow_mark[i] = MARK_EMPTY;
			shadow_count = 0;
		end else begin
			// probe at offsets growing by even steps; removed slots do not stop the search
			idx       = k % SLOTS;
			step      = 0;
			searching = 1'b1;
			for (int n = 0; n < SLOTS && searching; n++) begin
				if (shadow_mark[idx] == MARK_ACTIVE) begin
					if (shadow_key[idx] == k) begin
						hit       = idx;
						searching = 1'b0;
					end
				end else begin
					if (free_slot == SLOTS) free_slot = idx;
					if (shadow_mark[idx] == MARK_EMPTY) searching = 1'b0;
				end
				idx  = (idx + step) % SLOTS;
				step = step + PROBE_STEP;
			end
			case (cmd)
				CMD_GET: begin
					if (hit < SLOTS) r.value = shadow_val[hit];
					else r.status = ST_NOT_FOUND;
				end
				CMD_SET: begin
					if (hit < SLOTS) begin
						shadow_val[hit] = v;
					end else if (free_slot < SLOTS) begin
						shadow_key[free_slot]  = k;
						shadow_val[free_slot]  = v;
						shadow_mark[free_slot] = MARK_ACTIVE;
						shadow_count++;
					end else begin
						r.status = ST_FULL;
					end
				end
				default: begin
					if (hit < SLOTS) begin
						shadow_mark[hit] = MARK_REMOVED;
						if (shadow_count > 0) shadow_count--;
					end else begin
						r.status = ST_NOT_FOUND;
					end
				end
			endcase
		end
		r.used = shadow_count[CNT_W-1:0];
		return r;
	endfunction

	// Drive one command, hold it until the transfer, then log the expected result.
	task automatic issue_command(oaht_cmd_t cmd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		int unsigned gap;
		if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		command     <= cmd;
		key         <= k;
		write_value <= v;
		do @(posedge clk); while (busy);
		pending_results.push_back(table_lookup_update(cmd, k, v));
		commands_sent++;
	endtask

	// Compare every result against the oldest outstanding expectation.
	always @(posedge clk) begin : check_results
		table_result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (status == ST_FULL) full_seen++;
			if (entries_used > peak_used) peak_used = entries_used;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: status %0d read_value %h entries_used %0d",
					$time, status, read_value, entries_used);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					mismatches++;
				end
				if (read_value !== want.value) begin
					$display("%0t: read_value expected %h actual %h", $time, want.value,
						read_value);
					mismatches++;
				end
				if (entries_used !== want.used) begin
					$display("%0t: entries_used expected %0d actual %0d", $time, want.used,
						entries_used);
					mismatches++;
				end
			end
		end
	end

	// Extremes, overwrite, removal, probing past removed slots, full table and slot reuse.
	task automatic test_directed();
		issue_command(CMD_CLEAR, '0, '0);
		issue_command(CMD_GET, '0, '1);
		issue_command(CMD_DISCARD, '0, '0);
		issue_command(CMD_SET, '0, '0);
		issue_command(CMD_SET, '1, '1);
		issue_command(CMD_GET, '0, '0);
		issue_command(CMD_GET, '1, '0);
		issue_command(CMD_SET, '0, 32'hA5A5_5A5A);
		issue_command(CMD_GET, '0, '0);
		issue_command(CMD_DISCARD, '1, '0);
		issue_command(CMD_GET, '1, '0);
		// occupy every even slot: even homes can reach no other slot
		for (int k = 2; k < SLOTS; k += 2) issue_command(CMD_SET, k, ~k);
		issue_command(CMD_SET, 32'h10, 32'h1234_5678);
		issue_command(CMD_DISCARD, 32'h4, '0);
		issue_command(CMD_GET, 32'h14, '0);
		issue_command(CMD_SET, 32'h14, 32'hDEAD_BEEF);
		issue_command(CMD_GET, 32'h14, '0);
		issue_command(CMD_SET, 32'h24, 32'h0F0F_0F0F);
		issue_command(CMD_CLEAR, '1, '1);
		issue_command(CMD_GET, 32'h2, '0);
	endtask

	// Fill from a small key set with mostly sets, drain it with mostly discards, then clear.
	task automatic test_fill_and_drain(int unsigned rounds);
		logic [KEY_W-1:0] pool [20];
		int unsigned      pick;
		oaht_cmd_t        cmd;
		for (int r = 0; r < rounds; r++) begin
			foreach (pool[i]) pool[i] = $urandom();
			for (int n = 0; n < 100; n++) begin
				pick = $urandom_range(0, 99);
				if (n < 60) cmd = pick < 70 ? CMD_SET : (pick < 90 ? CMD_GET : CMD_DISCARD);
				else cmd = pick < 60 ? CMD_DISCARD : (pick < 90 ? CMD_GET : CMD_SET);
				if ($urandom_range(0, 9) == 0) issue_command(cmd, $urandom(), $urandom());
				else issue_command(cmd, pool[$urandom_range(0, 19)], $urandom());
			end
			issue_command(CMD_CLEAR, $urandom(), $urandom());
		end
	endtask

	// Uniform commands on fresh and pooled keys in equal measure, clears included.
	task automatic test_random_mix(int unsigned count);
		logic [KEY_W-1:0] pool [8];
		foreach (pool[i]) pool[i] = $urandom();
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 1) == 0)
				issue_command(oaht_cmd_t'($urandom_range(0, 3)), $urandom(), $urandom());
			else
				issue_command(oaht_cmd_t'($urandom_range(0, 3)), pool[$urandom_range(0, 7)],
					$urandom());
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_fill_and_drain(4);
		test_random_mix(120);
		start <= 1'b0;
		// drain outstanding results, then allow for the longest command
		while (pending_results.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
		$display("Covered %0d commands (get, set, discard, clear) and checked %0d results.",
			commands_sent, results_seen);
		$display("Table-full results: %0d, peak entries in use: %0d.", full_seen, peak_used);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
